[design/byte_ring_fifo_with_drop_count_defines.svh]
// Assertion macros for the byte ring FIFO checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef BYTE_RING_FIFO_WITH_DROP_COUNT_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_DROP_COUNT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BRFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BRFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/brfd_pkg.sv]
// Package for the byte ring FIFO: request/result types, opcodes, states.
// No dependencies.
`default_nettype none

package brfd_pkg;

    localparam int RING_BYTES_DEF = 4096;
    localparam int MAX_BURST_DEF  = 64;

    localparam int BYTE_W  = 8;
    localparam int TAKE_W  = 7;
    localparam int DROP_W  = 32;

    // Request opcodes (code 3 is unused and treated as a no-op)
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] data_byte;
        logic              piece_last;
        logic [TAKE_W-1:0] take_limit;
    } req_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              result_last;
        logic [TAKE_W-1:0] taken_count;
        logic              push_accepted;
        logic              text_ready;
        logic [DROP_W-1:0] dropped_total;
    } res_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

`default_nettype wire

[design/brfd_ring_mem.sv]
// Ring byte store: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module brfd_ring_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/brfd_ctrl.sv]
// Ring FIFO control: indices, piece commit, drop counter, pop burst
// sequencing and the result register. Depends on brfd_pkg.
`default_nettype none

module brfd_ctrl #(
    parameter int RING_BYTES = brfd_pkg::RING_BYTES_DEF,
    parameter int MAX_BURST  = brfd_pkg::MAX_BURST_DEF,
    parameter int AW         = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire brfd_pkg::req_item_t req,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output brfd_pkg::res_item_t      res,
    output logic                     mem_wr_en,
    output logic [AW-1:0]            mem_wr_addr,
    output logic [7:0]               mem_wr_data,
    output logic                     mem_rd_en,
    output logic [AW-1:0]            mem_rd_addr,
    input  wire logic [7:0]          mem_rd_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(RING_BYTES - 1);
    localparam logic [brfd_pkg::TAKE_W-1:0] BURST_CAP = brfd_pkg::TAKE_W'(MAX_BURST);

    brfd_pkg::state_t state_reg, state_next;

    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] cm_idx_reg, cm_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [brfd_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic dropping_reg, dropping_next;
    logic wrote_reg, wrote_next;

    logic [brfd_pkg::TAKE_W-1:0] limit_reg, limit_next;
    logic [brfd_pkg::TAKE_W-1:0] cnt_reg, cnt_next;

    logic pend_reg, pend_next;
    logic pend_last_reg, pend_last_next;
    logic [brfd_pkg::TAKE_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic out_valid_reg, out_valid_next;
    brfd_pkg::res_item_t out_reg, out_next;

    logic [AW-1:0] wr_idx_inc, rd_idx_inc, wr_idx_after;
    logic [brfd_pkg::TAKE_W-1:0] limit_sat, issue_cnt;
    logic out_free, req_fire, pop_empty, move, issue, issue_fin;
    logic ring_full, store, drop_inc, wrote_after;

    // Ring index increments with wrap
    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + AW'(1);
    assign rd_idx_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + AW'(1);

    // Handshake and burst bookkeeping
    assign out_free  = !out_valid_reg || res_ready;
    assign req_ready = (state_reg == brfd_pkg::ST_IDLE) && !pend_reg && out_free;
    assign req_fire  = req_valid && req_ready;
    assign limit_sat = (req.take_limit > BURST_CAP) ? BURST_CAP : req.take_limit;
    assign pop_empty = (limit_sat == '0) || (rd_idx_reg == cm_idx_reg);
    assign move      = pend_reg && out_free;
    assign issue     = (state_reg == brfd_pkg::ST_POP) && (!pend_reg || move);
    assign issue_cnt = cnt_reg + brfd_pkg::TAKE_W'(1);
    assign issue_fin = (issue_cnt >= limit_reg) || (rd_idx_inc == cm_idx_reg);

    // Push decision: one slot always stays empty
    assign ring_full    = (wr_idx_inc == rd_idx_reg);
    assign store        = !dropping_reg && !ring_full;
    assign drop_inc     = !dropping_reg && ring_full;
    assign wrote_after  = wrote_reg || store;
    assign wr_idx_after = store ? wr_idx_inc : wr_idx_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brfd_pkg::ST_IDLE:
            begin
                if (req_fire && (req.opcode == brfd_pkg::OP_POP) && !pop_empty)
                begin
                    state_next = brfd_pkg::ST_POP;
                end
            end
            brfd_pkg::ST_POP:
            begin
                if (issue && issue_fin)
                begin
                    state_next = brfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brfd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result register
    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        cm_idx_next    = cm_idx_reg;
        rd_idx_next    = rd_idx_reg;
        drop_next      = drop_reg;
        dropping_next  = dropping_reg;
        wrote_next     = wrote_reg;
        limit_next     = limit_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        mem_wr_en      = 1'b0;

        // Empty result template for push, flush, empty pop and no-op
        if (req_fire)
        begin
            out_next.out_byte      = '0;
            out_next.byte_valid    = 1'b0;
            out_next.result_last   = 1'b1;
            out_next.taken_count   = '0;
            out_next.push_accepted = 1'b0;
            out_next.text_ready    = 1'b0;
            out_next.dropped_total = drop_reg;
            out_valid_next         = 1'b1;

            unique case (req.opcode)
                brfd_pkg::OP_PUSH:
                begin
                    mem_wr_en              = store;
                    wr_idx_next            = wr_idx_after;
                    drop_next              = drop_reg + brfd_pkg::DROP_W'(drop_inc);
                    out_next.push_accepted = store;
                    out_next.dropped_total = drop_reg + brfd_pkg::DROP_W'(drop_inc);
                    if (req.piece_last)
                    begin
                        // Commit even when part of the piece was dropped
                        cm_idx_next         = wr_idx_after;
                        out_next.text_ready = wrote_after;
                        dropping_next       = 1'b0;
                        wrote_next          = 1'b0;
                    end
                    else
                    begin
                        dropping_next = dropping_reg || drop_inc;
                        wrote_next    = wrote_after;
                    end
                end
                brfd_pkg::OP_POP:
                begin
                    if (!pop_empty)
                    begin
                        limit_next     = limit_sat;
                        cnt_next       = '0;
                        out_valid_next = 1'b0;
                    end
                end
                brfd_pkg::OP_FLUSH:
                begin
                    rd_idx_next = cm_idx_reg;
                end
                default:
                begin
                    // Unused code: state untouched
                end
            endcase
        end

        // Hand the fetched byte to the result register
        if (move)
        begin
            out_next.out_byte      = mem_rd_data;
            out_next.byte_valid    = 1'b1;
            out_next.result_last   = pend_last_reg;
            out_next.taken_count   = pend_cnt_reg;
            out_next.push_accepted = 1'b0;
            out_next.text_ready    = 1'b0;
            out_next.dropped_total = drop_reg;
            out_valid_next         = 1'b1;
            pend_next              = 1'b0;
        end

        // Fetch the next byte of the burst
        if (issue)
        begin
            rd_idx_next    = rd_idx_inc;
            cnt_next       = issue_cnt;
            pend_next      = 1'b1;
            pend_last_next = issue_fin;
            pend_cnt_next  = issue_cnt;
        end
    end

    assign mem_wr_addr = wr_idx_reg;
    assign mem_wr_data = req.data_byte;
    assign mem_rd_en   = issue;
    assign mem_rd_addr = rd_idx_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brfd_pkg::ST_IDLE;
            wr_idx_reg    <= '0;
            cm_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            drop_reg      <= '0;
            dropping_reg  <= 1'b0;
            wrote_reg     <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            cm_idx_reg    <= cm_idx_next;
            rd_idx_reg    <= rd_idx_next;
            drop_reg      <= drop_next;
            dropping_reg  <= dropping_next;
            wrote_reg     <= wrote_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        pend_last_reg <= pend_last_next;
        pend_cnt_reg  <= pend_cnt_next;
        out_reg       <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

[design/byte_ring_fifo_with_drop_count.sv]
// Byte ring FIFO with drop count: top level. Depends on brfd_pkg,
// brfd_ring_mem and brfd_ctrl.
//
// Byte FIFO over a ring of RING_BYTES bytes (one slot always left empty,
// so it holds at most RING_BYTES-1). Push requests write one byte of a
// piece; the piece becomes visible to pops only on its last byte. A push
// into a full ring discards the rest of the piece and bumps the 32-bit
// wrapping drop count once. Push, flush and the unused opcode give one
// result each; requests may follow every cycle while the result side keeps
// up. A pop burst of n bytes (n at most MAX_BURST) first starts a read
// on the single read port of the ring memory, then moves the bytes one
// by one into the result register; the next request is taken in the
// cycle after the last byte of the burst has entered the result
// register, unless a result stall holds it back. An empty pop gives a
// single result. No clearing pass after reset: the ring is only read
// where it has been written.
`default_nettype none

module byte_ring_fifo_with_drop_count #(
    parameter int RING_BYTES = brfd_pkg::RING_BYTES_DEF,
    parameter int MAX_BURST  = brfd_pkg::MAX_BURST_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire brfd_pkg::req_item_t req,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output brfd_pkg::res_item_t      res
);

    localparam int AW = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    // Control and result register
    brfd_ctrl #(
        .RING_BYTES (RING_BYTES),
        .MAX_BURST  (MAX_BURST),
        .AW         (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Ring storage
    brfd_ring_mem #(
        .DEPTH (RING_BYTES),
        .AW    (AW)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

[design/brfd_checker.sv]
// Port-level checks for the byte ring FIFO, bound to the top level.
// Depends on brfd_pkg and byte_ring_fifo_with_drop_count_defines.svh.
`default_nettype none
`include "byte_ring_fifo_with_drop_count_defines.svh"

module brfd_checker #(
    parameter int MAX_BURST = brfd_pkg::MAX_BURST_DEF
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire brfd_pkg::res_item_t res
);

    logic [brfd_pkg::TAKE_W-1:0] burst_cap;
    logic                        res_stall;
    logic                        mid_burst;
    logic                        req_fire;
    logic                        pop_fields_ok;
    logic                        plain_fields_ok;

    assign burst_cap = brfd_pkg::TAKE_W'(MAX_BURST);
    assign res_stall = res_valid && !res_ready;
    assign mid_burst = res_valid && !res.result_last;
    assign req_fire  = req_valid && req_ready;

    // Field shapes of popped-byte and single results
    assign pop_fields_ok   = (res.taken_count != '0) && (res.taken_count <= burst_cap)
                             && !res.push_accepted && !res.text_ready;
    assign plain_fields_ok = res.result_last && (res.taken_count == '0)
                             && (res.out_byte == '0);

    // Stalled result holds
    `BRFD_ASSERT_NXT(a_res_hold, res_stall, res_valid && $stable(res), "result moved while stalled")

    // No new request while a burst still has bytes to deliver
    `BRFD_ASSERT_IMP(a_burst_blocks, mid_burst, !req_fire, "request taken mid-burst")

    // Popped bytes carry a count within the burst limit and no push flags
    `BRFD_ASSERT_IMP(a_pop_fields, res_valid && res.byte_valid, pop_fields_ok, "bad popped byte")

    // Non-byte results are single and empty
    `BRFD_ASSERT_IMP(a_plain_result, res_valid && !res.byte_valid, plain_fields_ok, "bad single result")

endmodule

bind byte_ring_fifo_with_drop_count brfd_checker #(
    .MAX_BURST (MAX_BURST)
) u_brfd_checker (.*);

`default_nettype wire

[bench/byte_ring_fifo_with_drop_count_test.sv]
// Self-checking bench for the byte ring FIFO with drop count: a scoreboard class
// predicts every result beat, plain tasks drive requests and an always block stalls results.
// Depends on brfd_pkg and byte_ring_fifo_with_drop_count.
`default_nettype none

module byte_ring_fifo_with_drop_count_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RING       = brfd_pkg::RING_BYTES_DEF;
    localparam int         BURST_MAX  = brfd_pkg::MAX_BURST_DEF;
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         QUIET_MAX  = 5000;
    localparam int         PRINT_MAX  = 40;

    // Ring predictor and store of expected result beats
    class ring_scoreboard;
        logic [7:0]          ring_bytes [RING];
        int unsigned         wr_commit;
        int unsigned         wr_work;
        int unsigned         rd_idx;
        logic [31:0]         drops;
        bit                  dropping;
        bit                  wrote;
        brfd_pkg::res_item_t pending [$];
        int                  errors;
        int                  requests_seen;
        int                  beats_seen;

        function new();
            wr_commit     = 0;
            wr_work       = 0;
            rd_idx        = 0;
            drops         = '0;
            dropping      = 1'b0;
            wrote         = 1'b0;
            errors        = 0;
            requests_seen = 0;
            beats_seen    = 0;
        endfunction

        function int unsigned step_index(int unsigned idx);
            return (idx == RING - 1) ? 0 : idx + 1;
        endfunction

        function brfd_pkg::res_item_t beat(logic [7:0] b, logic v, logic l, logic [6:0] n,
                                           logic acc, logic rdy);
            brfd_pkg::res_item_t x;
            x.out_byte      = b;
            x.byte_valid    = v;
            x.result_last   = l;
            x.taken_count   = n;
            x.push_accepted = acc;
            x.text_ready    = rdy;
            x.dropped_total = drops;
            return x;
        endfunction

        // work out the beats one accepted request causes
        function void note_request(brfd_pkg::req_item_t r);
            logic        acc;
            logic        rdy;
            int unsigned nx;
            int unsigned lim;
            int unsigned n;
            logic [7:0]  b;
            requests_seen++;
            case (r.opcode)
                brfd_pkg::OP_PUSH:
                begin
                    acc = 1'b0;
                    rdy = 1'b0;
                    if (!dropping)
                    begin
                        nx = step_index(wr_work);
                        if (nx == rd_idx)
                        begin
                            drops++;
                            dropping = 1'b1;
                        end
                        else
                        begin
                            ring_bytes[wr_work] = r.data_byte;
                            wr_work = nx;
                            wrote   = 1'b1;
                            acc     = 1'b1;
                        end
                    end
                    if (r.piece_last)
                    begin
                        wr_commit = wr_work;
                        rdy       = wrote;
                        dropping  = 1'b0;
                        wrote     = 1'b0;
                    end
                    pending.push_back(beat(8'h00, 1'b0, 1'b1, 7'd0, acc, rdy));
                end
                brfd_pkg::OP_POP:
                begin
                    lim = (r.take_limit > BURST_MAX) ? BURST_MAX : r.take_limit;
                    n   = 0;
                    while (n < lim && rd_idx != wr_commit)
                    begin
                        b      = ring_bytes[rd_idx];
                        rd_idx = step_index(rd_idx);
                        n++;
                        pending.push_back(beat(b, 1'b1, (n >= lim || rd_idx == wr_commit),
                                               n[6:0], 1'b0, 1'b0));
                    end
                    if (n == 0)
                        pending.push_back(beat(8'h00, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0));
                end
                brfd_pkg::OP_FLUSH:
                begin
                    rd_idx = wr_commit;
                    pending.push_back(beat(8'h00, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0));
                end
                default:
                    pending.push_back(beat(8'h00, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0));
            endcase
        endfunction

        task report(string msg);
            if (errors < PRINT_MAX)
                $display("%t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string nm, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("beat %0d %s got 0x%0h want 0x%0h", beats_seen, nm, got,
                                 want));
        endtask

        // compare one accepted result beat with the oldest expectation
        task check_result(brfd_pkg::res_item_t got);
            brfd_pkg::res_item_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("beat %0d arrived with nothing expected", beats_seen));
            end
            else
            begin
                want = pending.pop_front();
                compare_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
                compare_field("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
                compare_field("result_last", 32'(got.result_last), 32'(want.result_last));
                compare_field("taken_count", 32'(got.taken_count), 32'(want.taken_count));
                compare_field("push_accepted", 32'(got.push_accepted),
                              32'(want.push_accepted));
                compare_field("text_ready", 32'(got.text_ready), 32'(want.text_ready));
                compare_field("dropped_total", got.dropped_total, want.dropped_total);
            end
            beats_seen++;
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    brfd_pkg::req_item_t req = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    brfd_pkg::res_item_t res;

    int send_idle  = 0;
    int recv_stall = 0;
    int quiet      = 0;

    ring_scoreboard sb;

    byte_ring_fifo_with_drop_count uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #2 clk = ~clk;

    // result side: check accepted beats, stall at random
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res);
        res_ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
            begin
                quiet <= 0;
            end
            else if (quiet >= QUIET_MAX)
            begin
                $display("%t no handshake for %0d cycles", $realtime, quiet);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    function automatic brfd_pkg::req_item_t mk_req(logic [1:0] op, logic [7:0] d, logic l,
                                                   logic [6:0] t);
        brfd_pkg::req_item_t r;
        r.opcode     = op;
        r.data_byte  = d;
        r.piece_last = l;
        r.take_limit = t;
        return r;
    endfunction

    // present one request, with random idle cycles ahead of it
    task automatic send_request(input brfd_pkg::req_item_t r);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic push_piece(input int len);
        for (int i = 0; i < len; i++)
            send_request(mk_req(brfd_pkg::OP_PUSH, 8'($urandom_range(255)), (i == len - 1),
                                7'($urandom_range(127))));
    endtask

    task automatic pop_burst(input logic [6:0] lim);
        send_request(mk_req(brfd_pkg::OP_POP, 8'($urandom_range(255)),
                            1'($urandom_range(1)), lim));
    endtask

    task automatic flush_reads();
        send_request(mk_req(brfd_pkg::OP_FLUSH, 8'($urandom_range(255)),
                            1'($urandom_range(1)), 7'($urandom_range(127))));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // extremes, every opcode, open pieces, flush and saturation
    task automatic directed_requests();
        pop_burst(7'd5);
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h00, 1'b0, 7'h00));
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'hFF, 1'b0, 7'h7F));
        pop_burst(7'd64);
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'hA5, 1'b1, 7'h2A));
        pop_burst(7'd0);
        pop_burst(7'd2);
        pop_burst(7'd127);
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h11, 1'b0, 7'h55));
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h22, 1'b0, 7'h2A));
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h33, 1'b1, 7'h55));
        flush_reads();
        pop_burst(7'd64);
        send_request(mk_req(OP_UNUSED, 8'hFF, 1'b1, 7'h7F));
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h5A, 1'b1, 7'h00));
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'hC3, 1'b1, 7'h40));
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h7E, 1'b1, 7'h01));
        pop_burst(7'd1);
        pop_burst(7'd64);
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h80, 1'b0, 7'h00));
        flush_reads();
        send_request(mk_req(brfd_pkg::OP_PUSH, 8'h01, 1'b1, 7'h7F));
        pop_burst(7'd127);
    endtask

    // mostly whole pieces and pops, with some flushes and noise
    task automatic random_traffic(input int count);
        int made;
        int pick;
        int len;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                len = $urandom_range(1, 8);
                push_piece(len);
                made += len;
            end
            else if (pick < 80)
            begin
                if ($urandom_range(9) == 0)
                    pop_burst(7'($urandom_range(65, 127)));
                else
                    pop_burst(7'($urandom_range(0, 64)));
                made++;
            end
            else if (pick < 88)
            begin
                flush_reads();
                made++;
            end
            else if (pick < 93)
            begin
                send_request(mk_req(OP_UNUSED, 8'($urandom_range(255)),
                                    1'($urandom_range(1)), 7'($urandom_range(127))));
            end
            else
            begin
                send_request(mk_req(brfd_pkg::OP_PUSH, 8'($urandom_range(255)),
                                    1'($urandom_range(1)), 7'($urandom_range(127))));
                made++;
            end
        end
    endtask

    // reset, then phases of idling on each side
    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle  = 0;
        recv_stall = 0;
        directed_requests();
        random_traffic(20);
        wait_drained();

        send_idle  = 52;
        recv_stall = 0;
        random_traffic(20);
        wait_drained();

        send_idle  = 0;
        recv_stall = 52;
        random_traffic(20);
        wait_drained();

        send_idle  = 13;
        recv_stall = 13;
        random_traffic(20);
        wait_drained();

        // a pop burst is the longest the block can still be busy
        repeat (BURST_MAX + 40) @(posedge clk);

        $display("Ran %0d requests and checked %0d result beats over four stall phases.",
                 sb.requests_seen, sb.beats_seen);
        $display("Pieces cut short by a full ring: %0d; mismatches: %0d.", sb.drops,
                 sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/brfd_pkg.sv
design/brfd_ring_mem.sv
design/brfd_ctrl.sv
design/byte_ring_fifo_with_drop_count.sv
design/brfd_checker.sv
bench/byte_ring_fifo_with_drop_count_test.sv
